// ===== rtl/grp_pkg.sv =====
// glyph rectangle packer package: shared types and constants
// no dependencies
package grp_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCAN_STEP   = 2'd0,
    CFG_AREA_WIDTH  = 2'd1,
    CFG_AREA_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic       first_of_pass;
  } in_word_t;

  typedef struct packed {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic        placed;
  } out_word_t;

  // candidate and stored rectangle, signed coordinates wide enough for any area
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } rect_t;

  // control travelling along the chain of cells
  typedef struct packed {
    logic  start;
    rect_t cand;
  } chain_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROW,
    ST_TEST,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/glyph_rectangle_packer.sv =====
// glyph rectangle packer top level: scan sequencer driving a chain of store cells
// depends on grp_pkg and grp_cell
//
// usage
//   in channel (in_valid/in_ready/in_data) takes one rectangle word; out channel
//   (out_valid/out_ready/out_data) returns one position word per rectangle.
//   cfg_we/cfg_idx/cfg_data write scan_step, area_width, area_height while idle.
// timing
//   each candidate position is sent down a chain of MAX_RECTS cells, one cell
//   per cycle; the next candidate is launched only after the previous one has
//   left the end of the chain, and each change of row passes through ST_ROW.
//   the chain length sets how long a candidate test takes; one item is in
//   flight at a time.
// reset
//   rst clears the store, counters and pass state and loads the register
//   defaults (step 1, area 256 x 256).
// stalls
//   the result sits in an output register; a new item is taken while it waits,
//   but its result is held back until the earlier word has been taken.
module glyph_rectangle_packer #(
  parameter int unsigned MAX_RECTS    = 256,
  parameter int unsigned MAX_AREA_DIM = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  grp_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output grp_pkg::out_word_t               out_data,
  input  logic                             cfg_we,
  input  logic [grp_pkg::CfgIdxW-1:0]      cfg_idx,
  input  logic [grp_pkg::CfgDataW-1:0]     cfg_data
);

  localparam int unsigned CntW = $clog2(MAX_RECTS + 1);
  localparam int unsigned IdxW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

  // configuration registers
  logic [5:0]  scan_step;
  logic [12:0] area_width;
  logic [12:0] area_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_step   <= 6'd1;
      area_width  <= 13'd256;
      area_height <= 13'd256;
    end else if (cfg_we) begin
      case (grp_pkg::cfg_idx_t'(cfg_idx))
        grp_pkg::CFG_SCAN_STEP:   scan_step   <= cfg_data[5:0];
        grp_pkg::CFG_AREA_WIDTH:  area_width  <= cfg_data;
        grp_pkg::CFG_AREA_HEIGHT: area_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // pass state
  logic [CntW-1:0] stored_count;
  logic [1:0]      direction_counter;
  logic [7:0]      last_width;
  logic [7:0]      last_height;
  logic [11:0]     last_row;
  logic            have_last;
  logic            pass_failed;

  // item working registers
  grp_pkg::state_t    state, state_next;
  logic [7:0]         cur_w, cur_h;
  logic               resume;
  logic [1:0]         dir;
  logic signed [15:0] step;
  logic signed [15:0] aw, ah;
  logic signed [15:0] y, x;
  logic               res_placed;
  logic [11:0]        res_x, res_y;

  // chain wiring
  grp_pkg::chain_cmd_t cmd  [MAX_RECTS+1];
  logic                hit  [MAX_RECTS+1];
  logic                vld  [MAX_RECTS+1];
  logic                clear_store;
  logic                load_any;
  grp_pkg::rect_t      load_rect;
  logic                launch;

  assign cmd[0].start = launch;
  assign cmd[0].cand  = '{x: x, y: y, w: {8'd0, cur_w}, h: {8'd0, cur_h}};
  assign hit[0]       = 1'b0;
  assign vld[0]       = launch;

  for (genvar g = 0; g < MAX_RECTS; g++) begin : g_cells
    grp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear_store),
      .load      (load_any && (stored_count[IdxW-1:0] == IdxW'(g))
                  && (stored_count < CntW'(MAX_RECTS))),
      .load_rect (load_rect),
      .cmd_in    (cmd[g]),
      .hit_in    (hit[g]),
      .valid_in  (vld[g]),
      .cmd_out   (cmd[g+1]),
      .hit_out   (hit[g+1]),
      .valid_out (vld[g+1])
    );
  end

  // loop bounds
  logic signed [15:0] ylim, xlim;
  logic               row_ok, col_ok;
  logic               x_up;

  assign ylim   = ah - $signed({8'd0, cur_h});
  assign xlim   = aw - $signed({8'd0, cur_w});
  assign x_up   = dir[1];
  assign row_ok = (y > 16'sd0) && (y < ylim);
  assign col_ok = x_up ? (x < xlim) : (x > 16'sd0);

  logic in_fire, out_fire, out_load;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state == grp_pkg::ST_IDLE);
  // output register free, or freed at this edge
  assign out_load = (state == grp_pkg::ST_DONE) && (!out_valid || out_fire);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      grp_pkg::ST_IDLE:  if (in_fire) state_next = grp_pkg::ST_SETUP;
      grp_pkg::ST_SETUP: begin
        if (pass_failed || stored_count >= CntW'(MAX_RECTS)) begin
          state_next = grp_pkg::ST_DONE;
        end else begin
          state_next = grp_pkg::ST_ROW;
        end
      end
      grp_pkg::ST_ROW:  state_next = row_ok ? grp_pkg::ST_TEST : grp_pkg::ST_DONE;
      grp_pkg::ST_TEST: state_next = col_ok ? grp_pkg::ST_WAIT : grp_pkg::ST_ROW;
      grp_pkg::ST_WAIT: begin
        if (vld[MAX_RECTS]) begin
          state_next = hit[MAX_RECTS] ? grp_pkg::ST_TEST : grp_pkg::ST_DONE;
        end
      end
      grp_pkg::ST_DONE: if (out_load) state_next = grp_pkg::ST_IDLE;
      default: state_next = grp_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    launch      = (state == grp_pkg::ST_TEST) && col_ok;
    clear_store = (state == grp_pkg::ST_IDLE) && in_fire && in_data.first_of_pass;
    load_any    = (state == grp_pkg::ST_WAIT) && vld[MAX_RECTS] && !hit[MAX_RECTS];
    load_rect   = cmd[MAX_RECTS].cand;
  end

  logic signed [15:0] step_c;
  logic signed [15:0] aw_c, ah_c;
  logic               resume_c;
  logic [1:0]         dir_c;
  always_comb begin
    step_c = (scan_step == 6'd0) ? 16'sd1 :
             (scan_step > 6'd32) ? 16'sd32 : $signed({10'd0, scan_step});
    aw_c = ({3'd0, area_width} > 16'(MAX_AREA_DIM)) ? 16'(MAX_AREA_DIM)
                                                    : $signed({3'd0, area_width});
    ah_c = ({3'd0, area_height} > 16'(MAX_AREA_DIM)) ? 16'(MAX_AREA_DIM)
                                                     : $signed({3'd0, area_height});
    resume_c = have_last && (last_width <= cur_w) && (last_height <= cur_h);
    dir_c    = resume_c ? direction_counter - 2'd1 : direction_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= grp_pkg::ST_IDLE;
      stored_count      <= '0;
      direction_counter <= '0;
      last_width        <= '0;
      last_height       <= '0;
      last_row          <= '0;
      have_last         <= 1'b0;
      pass_failed       <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        grp_pkg::ST_IDLE: begin
          if (in_fire) begin
            cur_w      <= in_data.rect_width;
            cur_h      <= in_data.rect_height;
            res_placed <= 1'b0;
            res_x      <= '0;
            res_y      <= '0;
            if (in_data.first_of_pass) begin
              stored_count      <= '0;
              direction_counter <= '0;
              last_width        <= '0;
              last_height       <= '0;
              last_row          <= '0;
              have_last         <= 1'b0;
              pass_failed       <= 1'b0;
            end
          end
        end
        grp_pkg::ST_SETUP: begin
          step   <= step_c;
          aw     <= aw_c;
          ah     <= ah_c;
          resume <= resume_c;
          dir    <= dir_c;
          if (resume_c) y <= $signed({4'd0, last_row});
          else if (dir_c[0]) y <= ah_c - $signed({8'd0, cur_h}) - 16'sd1;
          else y <= 16'sd1;
          if (pass_failed || stored_count >= CntW'(MAX_RECTS)) pass_failed <= 1'b1;
        end
        grp_pkg::ST_ROW: begin
          x <= dir[1] ? 16'sd1 : xlim - 16'sd1;
          if (!row_ok) pass_failed <= 1'b1;
        end
        grp_pkg::ST_TEST: begin
          if (!col_ok) y <= dir[0] ? y - step : y + step;
        end
        grp_pkg::ST_WAIT: begin
          if (vld[MAX_RECTS]) begin
            if (hit[MAX_RECTS]) begin
              x <= x_up ? x + step : x - step;
            end else begin
              res_placed   <= 1'b1;
              res_x        <= x[11:0];
              res_y        <= y[11:0];
              stored_count <= stored_count + CntW'(1);
              last_width   <= cur_w;
              last_height  <= cur_h;
              last_row     <= y[11:0];
              have_last    <= 1'b1;
              if (!resume) direction_counter <= direction_counter + 2'd1;
            end
          end
        end
        grp_pkg::ST_DONE: begin
          if (out_load) begin
            out_data.pos_x   <= res_x;
            out_data.pos_y   <= res_y;
            out_data.placed  <= res_placed;
          end
        end
        default: ;
      endcase
      out_valid <= out_load ? 1'b1 : (out_fire ? 1'b0 : out_valid);
    end
  end

endmodule

// ===== rtl/grp_cell.sv =====
// glyph rectangle packer: one store cell, holds one placed rectangle
// depends on grp_pkg
module grp_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              load,
  input  grp_pkg::rect_t    load_rect,
  input  grp_pkg::chain_cmd_t cmd_in,
  input  logic              hit_in,
  input  logic              valid_in,
  output grp_pkg::chain_cmd_t cmd_out,
  output logic              hit_out,
  output logic              valid_out
);

  grp_pkg::rect_t held;
  logic           full;
  logic           overlap;

  always_comb begin
    overlap = full &&
              (cmd_in.cand.x <= held.x + held.w) &&
              (cmd_in.cand.x + cmd_in.cand.w >= held.x) &&
              (cmd_in.cand.y <= held.y + held.h) &&
              (cmd_in.cand.y + cmd_in.cand.h >= held.y);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      full      <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      if (load) begin
        full <= 1'b1;
      end
      valid_out <= valid_in;
    end
    if (load) begin
      held <= load_rect;
    end
    cmd_out <= cmd_in;
    hit_out <= hit_in | (valid_in & overlap);
  end

endmodule

// ===== test/tb_glyph_rectangle_packer.sv =====
// testbench for glyph_rectangle_packer: directed and random rectangle passes
// checked against an in-bench placement predictor
// depends on grp_pkg and the glyph_rectangle_packer rtl
module tb_glyph_rectangle_packer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRects = 256;
  localparam int MaxDim = 4096;
  localparam int WantDepth = 1024;
  // quiet cycles before a register write: one candidate test runs the whole chain
  localparam int SettleCycles = 600;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  grp_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  grp_pkg::out_word_t out_data;
  logic cfg_we;
  logic [grp_pkg::CfgIdxW-1:0] cfg_idx;
  logic [grp_pkg::CfgDataW-1:0] cfg_data;

  glyph_rectangle_packer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // predictor copy of the packer state and registers
  int placed_x[NumRects];
  int placed_y[NumRects];
  int placed_w[NumRects];
  int placed_h[NumRects];
  int placed_count;
  logic [1:0] dir_count;
  int prev_w, prev_h, prev_row;
  bit have_prev;
  bit pass_dead;
  int step_reg, width_reg, height_reg;

  // expected words in order, written by the sender and read by the checker
  grp_pkg::out_word_t want_words[WantDepth];
  int want_wr;
  int want_rd;
  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;

  // a new pass starts from an empty area
  function automatic void clear_area();
    placed_count = 0;
    dir_count = 2'd0;
    prev_w = 0;
    prev_h = 0;
    prev_row = 0;
    have_prev = 0;
    pass_dead = 0;
  endfunction

  // touching edges count as a hit
  function automatic bit hits_placed(int x, int y, int w, int h);
    for (int i = 0; i < placed_count; i++) begin
      if (x <= placed_x[i] + placed_w[i] && x + w >= placed_x[i] &&
          y <= placed_y[i] + placed_h[i] && y + h >= placed_y[i])
        return 1;
    end
    return 0;
  endfunction

  function automatic grp_pkg::out_word_t place_rect(grp_pkg::in_word_t wd);
    grp_pkg::out_word_t res;
    int w, h, stp, aw, ah, y, x, y0, dy, x0, dx;
    logic [1:0] dir;
    bit resumed, fit;
    int fx, fy;
    w = wd.rect_width;
    h = wd.rect_height;
    fit = 0;
    fx = 0;
    fy = 0;
    res = '0;
    if (wd.first_of_pass) clear_area();
    if (pass_dead) return res;
    if (placed_count >= NumRects) begin
      pass_dead = 1;
      return res;
    end
    stp = (step_reg < 1) ? 1 : (step_reg > 32) ? 32 : step_reg;
    aw = (width_reg > MaxDim) ? MaxDim : width_reg;
    ah = (height_reg > MaxDim) ? MaxDim : height_reg;
    resumed = have_prev && prev_w <= w && prev_h <= h;
    if (resumed) begin
      // resumed scan reuses the previous direction and row
      dir = dir_count - 2'd1;
      dy = dir[0] ? -stp : stp;
      y0 = prev_row;
    end else begin
      dir = dir_count;
      if (dir[0]) begin
        y0 = ah - h - 1;
        dy = -stp;
      end else begin
        y0 = 1;
        dy = stp;
      end
    end
    for (y = y0; y > 0 && y < ah - h && !fit; y += dy) begin
      if (dir[1]) begin
        x0 = 1;
        dx = stp;
      end else begin
        x0 = aw - w - 1;
        dx = -stp;
      end
      for (x = x0; (dx > 0) ? (x < aw - w) : (x > 0); x += dx) begin
        if (!hits_placed(x, y, w, h)) begin
          fit = 1;
          fx = x;
          fy = y;
          break;
        end
      end
    end
    if (!fit) begin
      pass_dead = 1;
      return res;
    end
    placed_x[placed_count] = fx;
    placed_y[placed_count] = fy;
    placed_w[placed_count] = w;
    placed_h[placed_count] = h;
    placed_count++;
    prev_w = w;
    prev_h = h;
    prev_row = fy & 12'hFFF;
    have_prev = 1;
    if (!resumed) dir_count = dir_count + 2'd1;
    res.pos_x = fx[11:0];
    res.pos_y = fy[11:0];
    res.placed = 1'b1;
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver side stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result checker against the oldest expected word
  always @(posedge clk) begin
    grp_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (want_rd == want_wr) begin
        $error("result word with nothing expected: %p", out_data);
        fail_count++;
      end else begin
        want = want_words[want_rd % WantDepth];
        want_rd++;
        if (out_data.pos_x !== want.pos_x) begin
          $error("pos_x expected %0d actual %0d", want.pos_x, out_data.pos_x);
          fail_count++;
        end
        if (out_data.pos_y !== want.pos_y) begin
          $error("pos_y expected %0d actual %0d", want.pos_y, out_data.pos_y);
          fail_count++;
        end
        if (out_data.placed !== want.placed) begin
          $error("placed expected %0b actual %0b", want.placed, out_data.placed);
          fail_count++;
        end
      end
    end
  end

  // one rectangle word; valid stays high across back-to-back words
  task automatic send_rect(int w, int h, bit first);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{rect_width: w[7:0], rect_height: h[7:0], first_of_pass: first};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want_words[want_wr % WantDepth] = place_rect('{rect_width: w[7:0],
                                                   rect_height: h[7:0],
                                                   first_of_pass: first});
    want_wr++;
  endtask

  // drop valid, let every result come back, then let the chain settle
  task automatic drain();
    in_valid <= 1'b0;
    while (want_rd != want_wr) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // register writes only while idle
  task automatic write_reg(grp_pkg::cfg_idx_t idx, int value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[grp_pkg::CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      grp_pkg::CFG_SCAN_STEP: step_reg = value & 32'h3F;
      grp_pkg::CFG_AREA_WIDTH: width_reg = value & 32'h1FFF;
      default: height_reg = value & 32'h1FFF;
    endcase
  endtask

  task automatic set_area(int stp, int aw, int ah);
    write_reg(grp_pkg::CFG_SCAN_STEP, stp);
    write_reg(grp_pkg::CFG_AREA_WIDTH, aw);
    write_reg(grp_pkg::CFG_AREA_HEIGHT, ah);
  endtask

  // reset defaults, resumed row scan, no-fit rectangle and a dead pass
  task automatic test_defaults();
    send_idle_pct = 15;
    recv_idle_pct = 50;
    send_rect(40, 30, 1);
    send_rect(40, 30, 0);    // same size resumes at the last row
    send_rect(10, 10, 0);
    send_rect(12, 12, 0);    // larger than last, resumes again
    send_rect(255, 0, 0);    // too wide for the area
    send_rect(0, 0, 0);      // pass already failed
    send_rect(255, 255, 1);  // too tall, fails at once
    send_rect(0, 0, 1);
    drain();
  endtask

  // extreme register values, including out-of-range step and area
  task automatic test_register_extremes();
    send_idle_pct = 50;
    recv_idle_pct = 15;
    set_area(63, 8191, 8191);  // step clamps to 32, area to the maximum
    send_rect(255, 255, 1);
    send_rect(255, 255, 0);
    send_rect(1, 1, 0);
    drain();
    set_area(0, 4096, 4096);   // zero step acts as one
    send_rect(200, 170, 1);
    send_rect(85, 3, 0);
    send_rect(2, 250, 0);
    send_rect(0, 0, 0);
    drain();
    set_area(32, 16, 16);      // smallest area
    send_rect(0, 0, 1);
    send_rect(0, 0, 0);
    send_rect(14, 14, 0);
    send_rect(0, 0, 0);
    drain();
  endtask

  // random passes, biggest first, with some out-of-order noise
  task automatic test_random_passes();
    int sent, w, h, len, phase;
    sent = 0;
    phase = -1;
    while (sent < 120) begin
      if (sent / 40 != phase) begin
        phase = sent / 40;
        send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 50 : 0;
        recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 15 : 0;
      end
      drain();
      // keep candidate counts small so each item stays short
      if ($urandom_range(0, 1))
        set_area($urandom_range(16, 32), $urandom_range(16, 256), $urandom_range(16, 256));
      else
        set_area($urandom_range(8, 32), $urandom_range(16, 128), $urandom_range(16, 128));
      len = $urandom_range(3, 10);
      w = $urandom_range(0, 80);
      h = $urandom_range(0, 80);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_rect($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
        else
          send_rect(w, h, i == 0);
        sent++;
        if ($urandom_range(0, 2) != 0) begin
          w = $urandom_range(0, w);
          h = $urandom_range(0, h);
        end
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    want_wr = 0;
    want_rd = 0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    step_reg = 1;
    width_reg = 256;
    height_reg = 256;
    clear_area();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_register_extremes();
    test_random_passes();
    if (fail_count == 0) $display("[glyph_rectangle_packer] OK");
    else $display("[glyph_rectangle_packer] ERROR");
    $finish;
  end

  // overall limit, far beyond the slowest passing run
  initial begin
    #200ms;
    $display("[glyph_rectangle_packer] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/grp_pkg.sv
rtl/grp_cell.sv
rtl/glyph_rectangle_packer.sv
test/tb_glyph_rectangle_packer.sv
